/* hdl/boot_region_bump_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// boot region allocator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BOOT_REGION_BUMP_ALLOCATOR_TOP_DEFINES_SVH
`define BOOT_REGION_BUMP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BRA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bra assertion failed");

// next-cycle implication
`define BRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bra assertion failed");

`endif

/* hdl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// shared types and constants of the boot region allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bra_pkg;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int PAGE_BYTES_DEF  = 4096;

	localparam int ADDR_W  = 64;
	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 32;
	localparam int PAGES_W = 52;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END   = 2'd1;

	localparam logic [KIND_W-1:0] KIND_RAM = 32'd1;

	// request token walking the cell chain
	typedef struct packed {
		logic              is_query;
		logic              stop;
		logic              hit;
		logic [ADDR_W-1:0] key;   // reserve size or query base
		logic [ADDR_W-1:0] qend;
		logic [ADDR_W-1:0] addr;
	} tok_t;

	// region load into one cell
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] fs;
		logic [ADDR_W-1:0] lim;
	} wr_t;

endpackage

/* hdl/bra_req_if.sv */
// ----------------------------------------------------------------------------
// bra_req_if
// request channel: function code and its operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bra_req_if
	import bra_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [ADDR_W-1:0]  entry_base;
	logic [ADDR_W-1:0]  entry_length;
	logic [KIND_W-1:0]  entry_kind;
	logic [PAGES_W-1:0] page_count;
	logic [ADDR_W-1:0]  query_base;
	logic [ADDR_W-1:0]  query_bytes;

	modport source (output valid, func, entry_base, entry_length, entry_kind,
		page_count, query_base, query_bytes, input ready);
	modport sink (input valid, func, entry_base, entry_length, entry_kind,
		page_count, query_base, query_bytes, output ready);
endinterface

/* hdl/bra_rsp_if.sv */
// ----------------------------------------------------------------------------
// bra_rsp_if
// response channel: status, reserved address and query answer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bra_rsp_if
	import bra_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] reserved_address;
	logic              block_usable;

	modport source (output valid, status, reserved_address, block_usable, input ready);
	modport sink (input valid, status, reserved_address, block_usable, output ready);
endinterface

/* hdl/bra_cfg_if.sv */
// ----------------------------------------------------------------------------
// bra_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bra_cfg_if
	import bra_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/bra_cell.sv */
// ----------------------------------------------------------------------------
// bra_cell
// one region slot: holds free start and end, inspects the passing token
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_cell
	import bra_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic live,
	input  wr_t  wr,
	input  logic in_valid,
	input  tok_t in_tok,
	output logic out_valid,
	output tok_t out_tok
);

	logic [ADDR_W-1:0] fs_q;
	logic [ADDR_W-1:0] lim_q;
	logic              valid_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              act;
	logic              fit;
	logic              covers;

	assign act    = in_valid && live && !in_tok.stop;
	// strictly more free space than the request
	assign fit    = (lim_q > fs_q) && ((lim_q - fs_q) > in_tok.key);
	assign covers = (fs_q <= in_tok.key) && (in_tok.qend <= lim_q);

	always_comb begin
		tok_d = in_tok;
		if (act && in_tok.is_query && covers) begin
			tok_d.stop = 1'b1;
			tok_d.hit  = 1'b1;
		end else if (act && !in_tok.is_query && fit) begin
			tok_d.stop = 1'b1;
			tok_d.hit  = 1'b1;
			tok_d.addr = fs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (wr.en) begin
			fs_q  <= wr.fs;
			lim_q <= wr.lim;
		end else if (act && !in_tok.is_query && fit) begin
			fs_q <= fs_q + in_tok.key;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

/* hdl/boot_region_bump_allocator_top.sv */
// Boot region allocator: keeps up to MAX_REGIONS free memory regions in a row of
// cells. An add request goes from transfer to the done state and then to the
// response register. Reserve and query requests send a token down the cell row,
// one cell per cycle, and are done once it leaves the last cell; the next request
// is taken once the previous result sits in the response register.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
// boot_region_bump_allocator_top
// request control, kernel image registers and the region cell row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "boot_region_bump_allocator_top_defines.svh"

module boot_region_bump_allocator_top
	import bra_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF,
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bra_req_if.sink   req,
	bra_rsp_if.source rsp,
	bra_cfg_if.sink   cfg
);

	localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int WIDE_W     = PAGES_W + 17;
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
	localparam logic [ADDR_W-1:0] PAGE_LEN  = ADDR_W'(PAGE_BYTES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] ks_rnd_q;
	logic [ADDR_W-1:0] kend_q;
	logic [ADDR_W-1:0] ke_rnd_q;
	logic              head_valid_q;
	tok_t              head_tok_q;

	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_usable_q;
	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic              rsp_usable_q;

	logic              req_xfer;
	logic              out_free;
	logic              full;
	logic              add_commit;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] fs_new;
	logic [ADDR_W-1:0] cfg_rnd;
	logic [WIDE_W-1:0] size_wide;
	logic [ADDR_W-1:0] size;
	logic [ADDR_W-1:0] qend;

	logic [MAX_REGIONS-1:0] live;
	logic [MAX_REGIONS-1:0] cv;
	tok_t                   ct [MAX_REGIONS];
	wr_t                    wr_cmd;

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign full = (count_q == CNT_W'(MAX_REGIONS));

	// add path
	assign base   = (req.entry_base > PAGE_LEN) ? req.entry_base : PAGE_LEN;
	assign fs_new = ((base >= ks_rnd_q) && (base <= kend_q)) ? ke_rnd_q : base;
	assign add_commit = req_xfer && (req.func == FUNC_ADD) &&
		(req.entry_kind == KIND_RAM) && !full;

	assign wr_cmd.en  = add_commit;
	assign wr_cmd.fs  = fs_new;
	assign wr_cmd.lim = req.entry_base + req.entry_length;

	// reserve size saturates at all ones
	assign size_wide = WIDE_W'(req.page_count) << PAGE_SHIFT;
	assign size = (|size_wide[WIDE_W-1:ADDR_W]) ? {ADDR_W{1'b1}} : size_wide[ADDR_W-1:0];
	assign qend = req.query_base + req.query_bytes;

	assign cfg_rnd = (cfg.data + PAGE_MASK) & ~PAGE_MASK;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
			wr_t cell_wr;
			assign live[gi] = (CNT_W'(gi) < count_q);
			assign cell_wr.en  = wr_cmd.en && (count_q == CNT_W'(gi));
			assign cell_wr.fs  = wr_cmd.fs;
			assign cell_wr.lim = wr_cmd.lim;
			if (gi == 0) begin : g_head
				bra_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.live     (live[gi]),
					.wr       (cell_wr),
					.in_valid (head_valid_q),
					.in_tok   (head_tok_q),
					.out_valid(cv[gi]),
					.out_tok  (ct[gi])
				);
			end else begin : g_body
				bra_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.live     (live[gi]),
					.wr       (cell_wr),
					.in_valid (cv[gi-1]),
					.in_tok   (ct[gi-1]),
					.out_valid(cv[gi]),
					.out_tok  (ct[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ks_rnd_q     <= '0;
			kend_q       <= '0;
			ke_rnd_q     <= '0;
			head_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_KERNEL_START) begin
					ks_rnd_q <= cfg_rnd;
				end else if (cfg.index == REG_KERNEL_END) begin
					kend_q   <= cfg.data;
					ke_rnd_q <= cfg_rnd;
				end
			end
			head_valid_q <= (state_q == ST_IDLE) && req_xfer &&
				(req.func == FUNC_RESERVE || req.func == FUNC_QUERY);
			if (add_commit) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						if (req.func == FUNC_RESERVE || req.func == FUNC_QUERY) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (cv[MAX_REGIONS-1]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_xfer) begin
			head_tok_q.is_query <= (req.func == FUNC_QUERY);
			head_tok_q.hit      <= 1'b0;
			head_tok_q.addr     <= '0;
			if (req.func == FUNC_QUERY) begin
				head_tok_q.key  <= req.query_base;
				head_tok_q.qend <= qend;
				// a block that wraps past the top is never usable
				head_tok_q.stop <= (qend < req.query_base);
			end else begin
				head_tok_q.key  <= size;
				head_tok_q.qend <= '0;
				head_tok_q.stop <= 1'b0;
			end
			res_addr_q   <= '0;
			res_usable_q <= 1'b0;
			res_status_q <= (req.func == FUNC_ADD && req.entry_kind == KIND_RAM && full)
				? STATUS_FULL : STATUS_OK;
		end else if (state_q == ST_WALK && cv[MAX_REGIONS-1]) begin
			res_status_q <= (!ct[MAX_REGIONS-1].is_query && !ct[MAX_REGIONS-1].hit)
				? STATUS_NO_SPACE : STATUS_OK;
			res_addr_q   <= ct[MAX_REGIONS-1].addr;
			res_usable_q <= ct[MAX_REGIONS-1].is_query && ct[MAX_REGIONS-1].hit;
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
			rsp_usable_q <= res_usable_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.reserved_address = rsp_addr_q;
	assign rsp.block_usable     = rsp_usable_q;

	`BRA_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_REGIONS))
	`BRA_ASSERT_IMPL(a_fail_zero_addr, rsp.valid && rsp.status != STATUS_OK,
		rsp.reserved_address == '0)
	`BRA_ASSERT_IMPL(a_usable_ok, rsp.valid && rsp.block_usable, rsp.status == STATUS_OK)
	`BRA_ASSERT_IMPL(a_full_count, rsp.valid && rsp.status == STATUS_FULL, full)
	`BRA_ASSERT_NEXT(a_walk_launch, req_xfer && req.func == FUNC_RESERVE,
		state_q == ST_WALK && head_valid_q)

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the boot region allocator: adds memory-map entries
// under several kernel image windows, then runs random reserve and query
// traffic against a cycle-free tracker of the region table, comparing every
// response field with the tracked answer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
	import bra_pkg::*;
;

	localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [ADDR_W-1:0]    PAGE_LEN    = ADDR_W'(PAGE_BYTES_DEF);
	localparam int                   PAGE_SHIFT  = $clog2(PAGE_BYTES_DEF);
	localparam int                   SETTLE      = 2 * MAX_REGIONS_DEF + 8;
	localparam int unsigned          CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ADDR_W-1:0]  entry_base;
		logic [ADDR_W-1:0]  entry_length;
		logic [KIND_W-1:0]  entry_kind;
		logic [PAGES_W-1:0] page_count;
		logic [ADDR_W-1:0]  query_base;
		logic [ADDR_W-1:0]  query_bytes;
	} req_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] reserved_address;
		logic              block_usable;
	} reply_t;

	// tracks the free-region table and the replies it owes
	class region_tracker;
		logic [ADDR_W-1:0] kern_start;
		logic [ADDR_W-1:0] kern_end;
		logic [ADDR_W-1:0] fs_tab [MAX_REGIONS_DEF];
		logic [ADDR_W-1:0] end_tab [MAX_REGIONS_DEF];
		int unsigned region_cnt;
		reply_t awaited_replies [$];
		int errors;
		int n_requests, n_checked, n_kept, n_full, n_unused;
		int n_granted, n_refused, n_queries, n_usable;

		function new();
			kern_start = '0;
			kern_end = '0;
			foreach (fs_tab[i]) begin
				fs_tab[i] = '0;
				end_tab[i] = '0;
			end
			region_cnt = 0;
			errors = 0;
			n_requests = 0;
			n_checked = 0;
			n_kept = 0;
			n_full = 0;
			n_unused = 0;
			n_granted = 0;
			n_refused = 0;
			n_queries = 0;
			n_usable = 0;
		endfunction

		function logic [ADDR_W-1:0] page_up(logic [ADDR_W-1:0] a);
			logic [ADDR_W-1:0] rem;
			rem = a & (PAGE_LEN - 1);
			if (rem == '0)
				return a;
			return a + (PAGE_LEN - rem);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
			if (idx == REG_KERNEL_START)
				kern_start = value;
			else if (idx == REG_KERNEL_END)
				kern_end = value;
		endfunction

		function void note_request(req_item_t it);
			reply_t rp;
			logic [ADDR_W-1:0] base, fs, size, space, qend, pages;
			bit found;
			rp = '0;
			found = 0;
			n_requests++;
			case (it.func)
			FUNC_ADD: begin
				if (it.entry_kind == KIND_RAM) begin
					if (region_cnt >= MAX_REGIONS_DEF) begin
						rp.status = STATUS_FULL;
						n_full++;
					end else begin
						base = (it.entry_base > PAGE_LEN) ? it.entry_base : PAGE_LEN;
						fs = base;
						// a base inside the kernel image starts past its page-rounded end
						if (base >= page_up(kern_start) && base <= kern_end)
							fs = page_up(kern_end);
						fs_tab[region_cnt] = fs;
						end_tab[region_cnt] = it.entry_base + it.entry_length;
						region_cnt++;
						n_kept++;
					end
				end
			end
			FUNC_RESERVE: begin
				pages = ADDR_W'(it.page_count);
				if (pages > {ADDR_W{1'b1}} / PAGE_LEN)
					size = '1;
				else
					size = pages * PAGE_LEN;
				for (int i = 0; i < int'(region_cnt) && !found; i++) begin
					space = (end_tab[i] > fs_tab[i]) ? end_tab[i] - fs_tab[i] : '0;
					if (space > size) begin
						rp.reserved_address = fs_tab[i];
						fs_tab[i] = fs_tab[i] + size;
						found = 1;
					end
				end
				if (found) begin
					n_granted++;
				end else begin
					rp.status = STATUS_NO_SPACE;
					n_refused++;
				end
			end
			FUNC_QUERY: begin
				n_queries++;
				qend = it.query_base + it.query_bytes;
				if (qend >= it.query_base) begin
					for (int i = 0; i < int'(region_cnt) && !found; i++) begin
						if (fs_tab[i] <= it.query_base && qend <= end_tab[i])
							found = 1;
					end
				end
				rp.block_usable = found;
				if (found)
					n_usable++;
			end
			default: begin
				n_unused++;
			end
			endcase
			awaited_replies.push_back(rp);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (awaited_replies.size() == 0) begin
				errors++;
				$error("response with nothing outstanding: status %0d address %h",
					got.status, got.reserved_address);
				return;
			end
			want = awaited_replies.pop_front();
			n_checked++;
			if (got.status !== want.status) begin
				errors++;
				$error("status: expected %0d, got %0d", want.status, got.status);
			end
			if (got.reserved_address !== want.reserved_address) begin
				errors++;
				$error("reserved_address: expected %h, got %h",
					want.reserved_address, got.reserved_address);
			end
			if (got.block_usable !== want.block_usable) begin
				errors++;
				$error("block_usable: expected %0b, got %0b",
					want.block_usable, got.block_usable);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle_pct = 14;
	int sink_idle_pct = 68;
	int hold_cycles = 0;
	int unsigned cycle_cnt = 0;
	region_tracker tracker = new();

	bra_req_if req ();
	bra_rsp_if rsp ();
	bra_cfg_if cfg ();

	boot_region_bump_allocator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// every transfer is seen here, at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				tracker.set_reg(cfg.index, cfg.data);
			if (req.valid && req.ready)
				tracker.note_request('{req.func, req.entry_base, req.entry_length,
					req.entry_kind, req.page_count, req.query_base, req.query_bytes});
			if (rsp.valid && rsp.ready)
				tracker.check_reply('{rsp.status, rsp.reserved_address, rsp.block_usable});
		end
	end

	// response side: random backpressure, plus a long hold-off on request
	initial begin
		int n;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				rsp.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	function automatic logic [ADDR_W-1:0] r64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic req_item_t add_req(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] len,
			logic [KIND_W-1:0] kind);
		req_item_t it;
		it = '0;
		it.func = FUNC_ADD;
		it.entry_base = base;
		it.entry_length = len;
		it.entry_kind = kind;
		return it;
	endfunction

	function automatic req_item_t reserve_req(logic [PAGES_W-1:0] pages);
		req_item_t it;
		it = '0;
		it.func = FUNC_RESERVE;
		it.page_count = pages;
		return it;
	endfunction

	function automatic req_item_t query_req(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes);
		req_item_t it;
		it = '0;
		it.func = FUNC_QUERY;
		it.query_base = base;
		it.query_bytes = bytes;
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// returns right after the rising edge of the transfer, valid still high
	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			req.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.func <= it.func;
		req.entry_base <= it.entry_base;
		req.entry_length <= it.entry_length;
		req.entry_kind <= it.entry_kind;
		req.page_count <= it.page_count;
		req.query_base <= it.query_base;
		req.query_bytes <= it.query_bytes;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		req.valid <= 1'b0;
		while (tracker.awaited_replies.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(input int n_items, input int ram_adds, input int src_pct,
			input int sink_pct);
		req_item_t it;
		int pick;
		int adds_left;
		int unsigned slot;
		logic [ADDR_W-1:0] lo, hi, room;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		adds_left = ram_adds;
		for (int n = 0; n < n_items; n++) begin
			// random filler in every operand; the function code decides what counts
			it.func = FUNC_UNUSED;
			it.entry_base = r64();
			it.entry_length = r64();
			it.entry_kind = $urandom();
			it.page_count = PAGES_W'(r64());
			it.query_base = r64();
			it.query_bytes = r64();
			pick = $urandom_range(0, 99);
			if (adds_left > 0 && (pick < 8 || n_items - n <= adds_left)) begin
				adds_left--;
				it.func = FUNC_ADD;
				it.entry_kind = KIND_RAM;
				if ($urandom_range(0, 6) != 0) begin
					if ($urandom_range(0, 1))
						it.entry_base = tracker.kern_start + ADDR_W'($urandom_range(0, 32'h3F_FFFF));
					else
						it.entry_base = {24'h0, 8'($urandom()), 32'($urandom())};
					if ($urandom_range(0, 1))
						it.entry_base[PAGE_SHIFT-1:0] = '0;
					it.entry_length = ADDR_W'($urandom_range(256, 1 << 20)) << PAGE_SHIFT;
				end
			end else if (pick < 18) begin
				it.func = FUNC_ADD;
				// usable entries only once the table is full
				if (tracker.region_cnt >= MAX_REGIONS_DEF && $urandom_range(0, 1))
					it.entry_kind = KIND_RAM;
				else if (it.entry_kind == KIND_RAM)
					it.entry_kind = ~KIND_RAM;
			end else if (pick < 50) begin
				it.func = FUNC_RESERVE;
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					it.page_count = PAGES_W'($urandom_range(0, 16));
				end else if (pick < 88 && tracker.region_cnt > 0) begin
					// right at the edge of one region's free space
					slot = $urandom_range(0, tracker.region_cnt - 1);
					lo = tracker.fs_tab[slot];
					hi = tracker.end_tab[slot];
					room = (hi > lo) ? hi - lo : '0;
					it.page_count = PAGES_W'((room >> PAGE_SHIFT) + ADDR_W'($urandom_range(0, 2))
						- ADDR_W'(1));
				end
			end else if (pick < 92) begin
				it.func = FUNC_QUERY;
				if (tracker.region_cnt > 0 && $urandom_range(0, 9) < 7) begin
					slot = $urandom_range(0, tracker.region_cnt - 1);
					lo = tracker.fs_tab[slot];
					hi = tracker.end_tab[slot];
					case ($urandom_range(0, 3))
					0: begin
						it.query_base = lo + ADDR_W'($urandom_range(0, PAGE_BYTES_DEF - 1));
						it.query_bytes = ADDR_W'($urandom_range(0, 65535));
					end
					1: begin
						it.query_base = lo;
						it.query_bytes = hi - lo;
					end
					2: begin
						it.query_base = lo;
						it.query_bytes = hi - lo + ADDR_W'(1);
					end
					default: begin
						it.query_base = lo - ADDR_W'(1);
						it.query_bytes = ADDR_W'(1);
					end
					endcase
				end else if ($urandom_range(0, 1)) begin
					it.query_bytes = ADDR_W'($urandom_range(0, 32'hF_FFFF));
				end
			end
			send_item(it);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] ks, ke;
		req.valid = 1'b0;
		req.func = FUNC_ADD;
		req.entry_base = '0;
		req.entry_length = '0;
		req.entry_kind = '0;
		req.page_count = '0;
		req.query_base = '0;
		req.query_bytes = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_KERNEL_START;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unaligned kernel start so the rounded start differs from the raw one
		write_reg(REG_KERNEL_START, 64'h0010_0800);
		write_reg(REG_KERNEL_END, 64'h0030_0123);
		send_item(query_req(64'h2000, 64'h10));
		send_item(reserve_req(52'd1));
		send_item(add_req(64'h0040_0000, 64'h0010_0000, 32'd2));
		send_item(add_req(64'h0, 64'h000A_0000, KIND_RAM));
		send_item(add_req(64'h0020_0000, 64'h0100_0000, KIND_RAM));
		send_item(add_req(64'h0010_1000, 64'h0010_0000, KIND_RAM));
		send_item(add_req(64'h0010_0800, 64'h800, KIND_RAM));
		send_item(add_req(64'h0030_0123, 64'h10_0000_0000, KIND_RAM));
		send_item(add_req(64'hFFFF_FFFF_FFFF_0000, 64'h2_0000, KIND_RAM));
		send_item(reserve_req(52'd0));
		send_item(reserve_req(52'd1));
		send_item(reserve_req('1));
		send_item(reserve_req(52'h9E));
		send_item(query_req(64'h2000, 64'h1000));
		send_item(query_req(64'h2000, 64'h9_E000));
		send_item(query_req(64'h2000, 64'h9_E001));
		send_item(query_req(64'hFFFF_FFFF_FFFF_F000, 64'h2000));
		send_item(query_req(64'h2000, 64'h0));
		send_item(query_req(64'h0, 64'h10));
		send_item(query_req('1, 64'h0));
		send_item('{FUNC_UNUSED, r64(), r64(), 32'($urandom()), PAGES_W'(r64()), r64(), r64()});
		send_item(add_req('1, '1, '1));
		send_item(add_req(64'h0080_0000, 64'h0010_0000, 32'h0001_0001));
		drain(SETTLE);

		write_reg(REG_KERNEL_START, '0);
		write_reg(REG_KERNEL_END, '0);
		run_phase(290, 3, 14, 68);
		drain(SETTLE);

		// both ends at the top of the space: the rounded start wraps to zero
		write_reg(REG_KERNEL_START, '1);
		write_reg(REG_KERNEL_END, '1);
		run_phase(290, 2, 14, 68);
		drain(SETTLE);

		ks = ADDR_W'($urandom_range(32'h0100_0000, 32'hF000_0000));
		ke = ks + ADDR_W'($urandom_range(0, 32'h1000_0000));
		write_reg(REG_KERNEL_START, ks);
		write_reg(REG_KERNEL_END, ke);
		write_reg(REG_SPARE_A, r64());
		write_reg(REG_SPARE_B, r64());
		// long response stall while requests keep coming
		hold_cycles = 300;
		run_phase(290, 3, 68, 14);
		drain(SETTLE);

		write_reg(REG_KERNEL_START, r64());
		write_reg(REG_KERNEL_END, r64());
		run_phase(290, 2, 68, 14);
		drain(SETTLE);

		// table is full from here on
		write_reg(REG_KERNEL_START, '0);
		write_reg(REG_KERNEL_END, '1);
		run_phase(290, 0, 0, 0);
		drain(SETTLE);

		$display("covered %0d requests: %0d regions kept, %0d adds refused full, %0d unused",
			tracker.n_requests, tracker.n_kept, tracker.n_full, tracker.n_unused);
		$display("reserves %0d granted / %0d refused, queries %0d usable of %0d, %0d checked",
			tracker.n_granted, tracker.n_refused, tracker.n_usable, tracker.n_queries,
			tracker.n_checked);
		if (tracker.errors == 0 && tracker.awaited_replies.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bra_pkg.sv
hdl/bra_req_if.sv
hdl/bra_rsp_if.sv
hdl/bra_cfg_if.sv
hdl/bra_cell.sv
hdl/boot_region_bump_allocator_top.sv
tb/sv/tb.sv
